// ===== src/lqr_pkg.sv =====
// Package for the linear queue with indexed removal.
// Holds default sizes and the command and status codes. No dependencies.
package lqr_pkg;

  // Default sizes of the queue storage.
  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;

  // Command codes carried by each input transaction.
  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_REMOVE = 2'd3
  } lqr_cmd_e;

  // Status codes returned with each result transaction.
  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_EMPTY  = 2'd2,
    STS_BADIDX = 2'd3
  } lqr_status_e;

endpackage

// ===== src/lqr_mem.sv =====
// Slot storage of the linear queue: one write port and one registered read port.
// Depends on lqr_pkg for its default sizes.
module lqr_mem import lqr_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  localparam int unsigned IdxW      = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [IdxW-1:0]       raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/linear_queue_with_indexed_removal_core.sv =====
// Top level of the linear queue with indexed removal: sequencer, pointers, result register.
// Depends on lqr_pkg and instantiates lqr_mem.
//
// A linear (non-circular) queue of DEPTH words with enqueue, dequeue, peek and
// removal at an absolute slot index; every input transaction yields exactly one
// result transaction with data, status and occupancy. One transaction is worked
// on at a time and in_stall_o is high until its result has been handed to the
// output register. Enqueue and refused commands are settled on acceptance,
// dequeue and peek add a storage read, and a removal at slot s reads that slot,
// then moves the entries above it down one at a time through the registered
// read port and the write port (one read and one write per entry). The output
// register lets a finished result wait while the next transaction is accepted;
// a second result then waits in the block until the first one is taken. The
// storage needs no clearing after reset, since only written slots are read.
module linear_queue_with_indexed_removal_core import lqr_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  localparam int unsigned IdxW      = $clog2(DEPTH),
  localparam int unsigned OccW      = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [IdxW-1:0]       slot_index_i,
  // Output channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [1:0]            status_o,
  output logic [OccW-1:0]       occupancy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } state_e;

  localparam logic [IdxW-1:0] LastSlot = IdxW'(DEPTH - 1);

  state_e                state_q, state_d;
  lqr_cmd_e              cmd_q, cmd_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       head_q, head_d;
  logic [IdxW-1:0]       tail_q, tail_d;
  logic                  empty_q, empty_d;
  logic [IdxW-1:0]       ptr_q, ptr_d;
  logic [DATA_WIDTH-1:0] res_data_q, res_data_d;
  lqr_status_e           res_status_q, res_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_data_q, out_data_d;
  lqr_status_e           out_status_q, out_status_d;
  logic [OccW-1:0]       out_occ_q, out_occ_d;

  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IdxW-1:0]       mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic [IdxW-1:0]       ptr_nx;
  logic [OccW-1:0]       occ_now;
  logic                  rm_finish;
  lqr_cmd_e              cmd_in;

  // Slot storage.
  lqr_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared incrementer of the shift loop and the current entry count.
  assign ptr_nx  = ptr_q + IdxW'(1);
  assign occ_now = empty_q ? '0 : OccW'(tail_q - head_q) + OccW'(1);
  assign cmd_in  = lqr_cmd_e'(command_i);

  // Sequencer: decodes a transaction, steps the shift loop, hands off the result.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    ptr_d        = ptr_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    mem_we       = 1'b0;
    mem_waddr    = tail_q;
    mem_wdata    = value_i;
    mem_re       = 1'b0;
    mem_raddr    = head_q;
    rm_finish    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_in;
          idx_d        = slot_index_i;
          res_data_d   = '0;
          res_status_d = STS_OK;
          state_d      = ST_DONE;
          unique case (cmd_in)
            CMD_ENQ: begin
              if (empty_q) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                head_d    = '0;
                tail_d    = '0;
                empty_d   = 1'b0;
              end else if (tail_q == LastSlot) begin
                res_status_d = STS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_q + IdxW'(1);
                tail_d    = tail_q + IdxW'(1);
              end
            end
            CMD_DEQ, CMD_PEEK: begin
              if (empty_q) begin
                res_status_d = STS_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                state_d   = ST_RD;
              end
            end
            CMD_REMOVE: begin
              if (empty_q) begin
                res_status_d = STS_EMPTY;
              end else if (slot_index_i < head_q || slot_index_i > tail_q) begin
                res_status_d = STS_BADIDX;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_index_i;
                state_d   = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        res_data_d = mem_rdata;
        state_d    = ST_DONE;
        unique case (cmd_q)
          CMD_DEQ: begin
            if (head_q >= tail_q) begin
              head_d  = '0;
              tail_d  = '0;
              empty_d = 1'b1;
            end else begin
              head_d = head_q + IdxW'(1);
            end
          end
          CMD_REMOVE: begin
            ptr_d = idx_q;
            if (idx_q < tail_q) begin
              state_d = ST_SH_RD;
            end else begin
              rm_finish = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_nx;
        state_d   = ST_SH_WR;
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = mem_rdata;
        ptr_d     = ptr_nx;
        if (ptr_nx < tail_q) begin
          state_d = ST_SH_RD;
        end else begin
          rm_finish = 1'b1;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_data_d   = res_data_q;
          out_status_d = res_status_q;
          out_occ_d    = occ_now;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // The tail steps back after a removal, or the queue drains on its last entry.
    if (rm_finish) begin
      if (tail_q <= head_q) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b1;
      end else begin
        tail_d = tail_q - IdxW'(1);
      end
    end
  end

  // State, pointers and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      empty_q      <= 1'b1;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= STS_OK;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      empty_q      <= empty_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_occ_q    <= out_occ_d;
    end
  end

  // Transaction payload and result registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    idx_q        <= idx_d;
    ptr_q        <= ptr_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;
  assign occupancy_o = out_occ_q;

  // An accepted transaction blocks the input until its result is handed off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again before the result was handed off");

  // An empty queue has both pointers at slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0) && (tail_q == '0))
    else $error("empty queue with pointers away from slot zero");

  // A held queue never has its head past its tail.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> head_q <= tail_q)
    else $error("head pointer past tail pointer");

  // An empty status always reports zero entries and zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_EMPTY) |-> (occupancy_o == '0) && (data_o == '0))
    else $error("empty status with entries or data");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for linear_queue_with_indexed_removal_core.
// Depends on lqr_pkg and the core; a built-in queue predictor checks every result
// transaction after a directed table and a long random run with idle bursts.
module tb_top;
  import lqr_pkg::*;

  localparam int unsigned Depth     = DepthDef;
  localparam int unsigned DataWidth = DataWidthDef;
  localparam int unsigned LastSlot  = Depth - 1;
  localparam int          RandItems = 800;
  localparam int          CalmItems = 100;

  typedef struct packed {
    logic [DataWidth-1:0] data;
    lqr_status_e          status;
    logic [4:0]           occupancy;
  } queue_result_t;

  typedef struct packed {
    lqr_cmd_e             cmd;
    logic [DataWidth-1:0] value;
    logic [3:0]           slot;
    logic                 has_fixed;
    queue_result_t        fixed;
  } stim_row_t;

  localparam int NumRows = 28;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           command_i;
  logic [DataWidth-1:0] value_i;
  logic [3:0]           slot_index_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DataWidth-1:0] data_o;
  logic [1:0]           status_o;
  logic [4:0]           occupancy_o;

  // Mirror of the queue contents and pointers.
  logic [DataWidth-1:0] mirror_slots [Depth];
  int unsigned          mirror_head;
  int unsigned          mirror_tail;
  bit                   mirror_empty;

  queue_result_t pending_results[$];
  int            n_errors;
  bit            calm_phase;

  // Directed table: the fixed result is typed in where it is obvious.
  stim_row_t directed_rows [NumRows] = '{
    '{CMD_DEQ,    32'h0000_0000, 4'd0,  1'b1, '{32'h0,         STS_EMPTY,  5'd0}},
    '{CMD_PEEK,   32'h0000_0000, 4'd0,  1'b1, '{32'h0,         STS_EMPTY,  5'd0}},
    '{CMD_REMOVE, 32'h0000_0000, 4'd0,  1'b1, '{32'h0,         STS_EMPTY,  5'd0}},
    '{CMD_ENQ,    32'h7FFF_FFFF, 4'd0,  1'b1, '{32'h0,         STS_OK,     5'd1}},
    '{CMD_REMOVE, 32'h0000_0000, 4'd0,  1'b1, '{32'h7FFF_FFFF, STS_OK,     5'd0}},
    '{CMD_ENQ,    32'h8000_0000, 4'd0,  1'b1, '{32'h0,         STS_OK,     5'd1}},
    '{CMD_ENQ,    32'hFFFF_FFFF, 4'd0,  1'b1, '{32'h0,         STS_OK,     5'd2}},
    '{CMD_PEEK,   32'h0000_0000, 4'd0,  1'b1, '{32'h8000_0000, STS_OK,     5'd2}},
    '{CMD_REMOVE, 32'h0000_0000, 4'd15, 1'b1, '{32'h0,         STS_BADIDX, 5'd2}},
    '{CMD_DEQ,    32'h0000_0000, 4'd0,  1'b1, '{32'h8000_0000, STS_OK,     5'd1}},
    '{CMD_REMOVE, 32'h0000_0000, 4'd0,  1'b1, '{32'h0,         STS_BADIDX, 5'd1}},
    '{CMD_ENQ,    32'h0000_0000, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'h5555_5555, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'hAAAA_AAAA, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'h0000_0001, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'h8000_0001, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'h1234_5678, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'hFEDC_BA98, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'h0F0F_0F0F, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'hF0F0_F0F0, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'h3333_3333, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'hCCCC_CCCC, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'h7FFF_FFFE, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'hDEAD_0001, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'h0BAD_F00D, 4'd0,  1'b0, '0},
    '{CMD_ENQ,    32'h1111_1111, 4'd0,  1'b1, '{32'h0,         STS_FULL,   5'd15}},
    '{CMD_REMOVE, 32'h0000_0000, 4'd8,  1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 4'd14, 1'b0, '0}
  };

  linear_queue_with_indexed_removal_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .slot_index_i (slot_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_o       (data_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

  // Applies one command to the mirror and returns the result it must produce.
  function automatic queue_result_t apply_command(lqr_cmd_e cmd, logic [DataWidth-1:0] word,
                                                  logic [3:0] idx);
    queue_result_t res;
    int unsigned   i;
    res = '{data: '0, status: STS_OK, occupancy: '0};
    if (cmd == CMD_ENQ) begin
      if (mirror_empty) begin
        mirror_head     = 0;
        mirror_tail     = 0;
        mirror_slots[0] = word;
        mirror_empty    = 1'b0;
      end else if (mirror_tail >= LastSlot) begin
        res.status = STS_FULL;
      end else begin
        mirror_tail++;
        mirror_slots[mirror_tail] = word;
      end
    end else if (mirror_empty) begin
      res.status = STS_EMPTY;
    end else if (cmd == CMD_DEQ) begin
      res.data = mirror_slots[mirror_head];
      if (mirror_head >= mirror_tail) begin
        mirror_head  = 0;
        mirror_tail  = 0;
        mirror_empty = 1'b1;
      end else begin
        mirror_head++;
      end
    end else if (cmd == CMD_PEEK) begin
      res.data = mirror_slots[mirror_head];
    end else if (idx < mirror_head || idx > mirror_tail) begin
      res.status = STS_BADIDX;
    end else begin
      // Entries above the removed slot close the gap.
      res.data = mirror_slots[idx];
      for (i = idx; i < mirror_tail; i++) begin
        mirror_slots[i] = mirror_slots[i+1];
      end
      if (mirror_tail <= mirror_head) begin
        mirror_head  = 0;
        mirror_tail  = 0;
        mirror_empty = 1'b1;
      end else begin
        mirror_tail--;
      end
    end
    res.occupancy = mirror_empty ? 5'd0 : 5'(mirror_tail - mirror_head + 1);
    return res;
  endfunction

  // Holds one input transaction until it is taken, then records its result.
  task automatic drive_item(stim_row_t row);
    queue_result_t predicted;
    in_valid_i   <= 1'b1;
    command_i    <= row.cmd;
    value_i      <= row.value;
    slot_index_i <= row.slot;
    @(negedge clk_i);
    while (in_stall_o !== 1'b0) @(negedge clk_i);
    predicted = apply_command(row.cmd, row.value, row.slot);
    pending_results.push_back(row.has_fixed ? row.fixed : predicted);
    @(posedge clk_i);
  endtask

  // Random idle burst on the input side.
  task automatic input_gap();
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Output-side stall bursts, switched off for the last part of the run.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm_phase && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 15)) @(posedge clk_i);
    end
  end

  // Result checker; outputs are stable at the falling edge before the taking edge.
  always @(negedge clk_i) begin
    queue_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result data=%h status=%0d occupancy=%0d",
                 $time, data_o, status_o, occupancy_o);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (data_o !== want.data) begin
          $display("%0t: data expected %h actual %h", $time, want.data, data_o);
          n_errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          n_errors++;
        end
        if (occupancy_o !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d",
                   $time, want.occupancy, occupancy_o);
          n_errors++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random traffic, then drain and report.
  initial begin
    stim_row_t row;
    bit        filling;
    int        pick;
    int        wait_cycles;
    n_errors      = 0;
    calm_phase    = 1'b0;
    mirror_head   = 0;
    mirror_tail   = 0;
    mirror_empty  = 1'b1;
    filling       = 1'b1;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    command_i    <= CMD_ENQ;
    value_i      <= '0;
    slot_index_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      input_gap();
      drive_item(directed_rows[r]);
    end

    for (int n = 0; n < RandItems; n++) begin
      calm_phase = (n >= RandItems - CalmItems);
      input_gap();
      // Alternate between filling and draining so full and empty are both reached.
      if (mirror_empty) begin
        filling = 1'b1;
      end else if (mirror_tail >= LastSlot) begin
        filling = 1'b0;
      end else if ($urandom_range(0, 39) == 0) begin
        filling = !filling;
      end
      pick = $urandom_range(0, 99);
      if (filling) begin
        row.cmd = (pick < 60) ? CMD_ENQ : (pick < 75) ? CMD_DEQ :
                  (pick < 85) ? CMD_PEEK : CMD_REMOVE;
      end else begin
        row.cmd = (pick < 20) ? CMD_ENQ : (pick < 55) ? CMD_DEQ :
                  (pick < 65) ? CMD_PEEK : CMD_REMOVE;
      end
      case ($urandom_range(0, 9))
        0:       row.value = 32'h7FFF_FFFF;
        1:       row.value = 32'h8000_0000;
        2:       row.value = {DataWidth{$urandom_range(0, 1) == 1}};
        default: row.value = $urandom;
      endcase
      if (!mirror_empty && $urandom_range(0, 99) < 85) begin
        row.slot = 4'($urandom_range(mirror_head, mirror_tail));
      end else begin
        row.slot = 4'($urandom_range(0, LastSlot));
      end
      row.has_fixed = 1'b0;
      row.fixed     = '0;
      drive_item(row);
    end
    in_valid_i <= 1'b0;

    // Wait for the remaining results, then give the block time to misbehave.
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (60) @(posedge clk_i);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      if (pending_results.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, pending_results.size());
      end
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
